FILE: rtl/core/assert_macros.svh
// Assertion helpers; clk and rst_n come from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`define ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/core/wpd_pkg.sv
package wpd_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int DIV_W = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [4:0] ST_OK          = 5'd0;
    localparam logic [4:0] ERR_CANCEL     = 5'd1;
    localparam logic [4:0] ERR_HDR_SHORT  = 5'd2;
    localparam logic [4:0] ERR_HDR_BAD    = 5'd3;
    localparam logic [4:0] ERR_LEN_SHORT  = 5'd4;
    localparam logic [4:0] ERR_FMT_LEN    = 5'd5;
    localparam logic [4:0] ERR_FMT_SHORT  = 5'd6;
    localparam logic [4:0] ERR_NOT_PCM    = 5'd7;
    localparam logic [4:0] ERR_CHANNELS   = 5'd8;
    localparam logic [4:0] ERR_RATE       = 5'd9;
    localparam logic [4:0] ERR_BITS       = 5'd10;
    localparam logic [4:0] ERR_ALIGN      = 5'd11;
    localparam logic [4:0] ERR_NO_FMT_YET = 5'd12;
    localparam logic [4:0] ERR_DATA_FRAC  = 5'd13;
    localparam logic [4:0] ERR_DATA_SHORT = 5'd14;
    localparam logic [4:0] ERR_DATA_EMPTY = 5'd15;
    localparam logic [4:0] ERR_SKIP_LEN   = 5'd16;
    localparam logic [4:0] ERR_FMT_MISS   = 5'd17;
    localparam logic [4:0] ERR_DATA_MISS  = 5'd18;

    typedef enum logic [5:0] {
        PH_HEAD = 6'b000001,
        PH_TAG  = 6'b000010,
        PH_SIZE = 6'b000100,
        PH_FMT  = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_DATA = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_PRE  = 4'b0010,
        C_DIV  = 4'b0100,
        C_EXEC = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic q_empty;
    } sts_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [4:0]         code;
        logic [31:0]        rate;
        logic [6:0]         chans;
        logic [31:0]        frames;
        logic               last;
    } res_t;

endpackage

FILE: rtl/core/wpd_div.sv
module wpd_div
    import wpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [7:0]       divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quo,
    output logic [7:0]       rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       dsr_reg, dsr_next;
    logic [8:0]       trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 8'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/wpd_outq.sv
`include "assert_macros.svh"

module wpd_outq
    import wpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push0_v,
    input  logic               push1_v,
    input  res_t               res0,
    input  res_t               res1,
    output logic               q_empty,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [15:0] mono_sample,
    output logic [4:0]         status_code,
    output logic [31:0]        rate_hz,
    output logic [6:0]         channels_in,
    output logic [31:0]        frames_total,
    output logic               last_result
);

    logic v0_reg, v1_reg;
    res_t s0_reg, s1_reg;
    logic pop;

    assign pop = v0_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (push0_v)
        begin
            v0_reg <= 1'b1;
            v1_reg <= push1_v;
        end
        else if (pop)
        begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0_v)
        begin
            s0_reg <= res0;
            s1_reg <= res1;
        end
        else if (pop)
            s0_reg <= s1_reg;
    end

    assign q_empty      = !v0_reg;
    assign out_valid    = v0_reg;
    assign kind         = s0_reg.kind;
    assign mono_sample  = s0_reg.sample;
    assign status_code  = s0_reg.code;
    assign rate_hz      = s0_reg.rate;
    assign channels_in  = s0_reg.chans;
    assign frames_total = s0_reg.frames;
    assign last_result  = s0_reg.last;

    `ASSERT_IMPLY(a_push_empty, push0_v, !v0_reg, "push into busy queue")
    `ASSERT_IMPLY(a_slot_order, v1_reg, v0_reg, "second slot valid without first")

endmodule

FILE: rtl/core/wpd_ctrl.sv
`include "assert_macros.svh"

module wpd_ctrl
    import wpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = C_PRE;
                end
            end
            C_PRE:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = C_DIV;
                end
                else
                    state_next = C_EXEC;
            end
            C_DIV:
            begin
                if (!sts.div_busy)
                    state_next = C_EXEC;
            end
            C_EXEC:
            begin
                if (sts.q_empty)
                begin
                    cmd.exec   = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != C_IDLE);

    `ASSERT_NEXT(a_div_launch, cmd.div_start, sts.div_busy, "divider did not start")
    `ASSERT_IMPLY(a_div_state, sts.div_busy, state_reg == C_DIV, "divider busy outside wait")
    `ASSERT_NEXT(a_accept_pre, in_valid && !in_stall, state_reg == C_PRE, "beat not latched")

endmodule

FILE: rtl/core/wpd_dp.sv
module wpd_dp
    import wpd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [7:0]       stream_byte,
    input  logic             end_of_file,
    input  logic             cancel,
    output logic             need_div,
    output logic [DIV_W-1:0] div_dividend,
    output logic [7:0]       div_divisor,
    input  logic [DIV_W-1:0] div_quo,
    input  logic [7:0]       div_rem,
    output logic             push0_v,
    output logic             push1_v,
    output res_t             res0,
    output res_t             res1
);

    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = 17 + $clog2(MAX_CHANNELS);

    logic [7:0] byte_reg;
    logic       eof_reg, cancel_reg;

    phase_t                   phase_reg, phase_next;
    logic [4:0]               fbi_reg, fbi_next;
    logic [31:0]              tag_reg, tag_next;
    logic [31:0]              len_reg, len_next;
    logic [32:0]              left_reg, left_next;
    logic [15:0]              code_reg, code_next;
    logic [15:0]              chan_reg, chan_next;
    logic [31:0]              rate_reg, rate_next;
    logic [15:0]              align_reg, align_next;
    logic [15:0]              bits_reg, bits_next;
    logic                     seen_reg, seen_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CH_W-1:0]          chidx_reg, chidx_next;
    logic [7:0]               low_reg, low_next;
    logic [31:0]              frames_reg, frames_next;
    logic                     fin_reg, fin_next;
    logic                     riff_reg, riff_next;

    logic [15:0]             raw, v16;
    logic signed [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0]        mag;
    logic [CH_W-1:0]         chidx_inc;
    logic                    frame_end, first_cancel;
    logic                    need_frame, need_chunk;
    logic [31:0]             len_full;

    logic        smp_v, term_v;
    logic [1:0]  term_kind;
    logic [4:0]  term_code;
    logic [15:0] smp;
    logic [3:0]  fi;
    logic [4:0]  chk;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg   <= stream_byte;
            eof_reg    <= end_of_file;
            cancel_reg <= cancel;
        end
    end

    assign raw          = {byte_reg, low_reg};
    assign v16          = (raw == 16'h8000) ? 16'h8001 : raw;
    assign sum_add      = sum_reg + {{(SUM_W-16){v16[15]}}, v16};
    assign mag          = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : sum_add;
    assign chidx_inc    = chidx_reg + 1'b1;
    assign frame_end    = ({{(16-CH_W){1'b0}}, chidx_inc} >= chan_reg);
    assign first_cancel = (chidx_reg == '0) && (fbi_reg == 5'd0) && cancel_reg;
    assign len_full     = {byte_reg, len_reg[23:0]};

    assign need_frame = (phase_reg == PH_DATA) && !fin_reg && !first_cancel
                        && (fbi_reg == 5'd1) && frame_end;
    assign need_chunk = (phase_reg == PH_SIZE) && !fin_reg && (fbi_reg == 5'd3)
                        && (tag_reg == TAG_DATA) && seen_reg;
    assign need_div   = need_frame || need_chunk;

    assign div_dividend = need_chunk ? len_full
                                     : DIV_W'({mag, 1'b0}) + DIV_W'(chan_reg);
    assign div_divisor  = need_chunk ? align_reg[7:0] : {chan_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        code_next   = code_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        align_next  = align_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        chidx_next  = chidx_reg;
        low_next    = low_reg;
        frames_next = frames_reg;
        fin_next    = fin_reg;
        riff_next   = riff_reg;
        smp_v       = 1'b0;
        term_v      = 1'b0;
        term_kind   = KIND_ERROR;
        term_code   = ST_OK;
        smp         = '0;
        fi          = fbi_reg[3:0];
        chk         = ST_OK;

        if (!fin_reg)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    if (fbi_reg == 5'd0 && cancel_reg)
                    begin
                        term_v = 1'b1; term_code = ERR_CANCEL; fin_next = 1'b1;
                    end
                    else
                    begin
                        tag_next = {byte_reg, tag_reg[31:8]};
                        fbi_next = fbi_reg + 1'b1;
                        if (fbi_next == 5'd4)
                            riff_next = (tag_next == TAG_RIFF);
                        if (fbi_next == 5'd12)
                        begin
                            if (!riff_reg || tag_next != TAG_WAVE)
                            begin
                                term_v = 1'b1; term_code = ERR_HDR_BAD; fin_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TAG;
                                fbi_next   = '0;
                            end
                        end
                    end
                end
                PH_TAG:
                begin
                    tag_next = {byte_reg, tag_reg[31:8]};
                    fbi_next = fbi_reg + 1'b1;
                    if (fbi_next >= 5'd4)
                    begin
                        phase_next = PH_SIZE;
                        fbi_next   = '0;
                        len_next   = '0;
                    end
                end
                PH_SIZE:
                begin
                    len_next[{fbi_reg[1:0], 3'b000} +: 8] = byte_reg;
                    fbi_next = fbi_reg + 1'b1;
                    if (fbi_next >= 5'd4)
                    begin
                        fbi_next = '0;
                        if (tag_reg == TAG_FMT)
                        begin
                            if (len_next < 32'd16)
                            begin
                                term_v = 1'b1; term_code = ERR_FMT_LEN; fin_next = 1'b1;
                            end
                            else
                            begin
                                code_next  = '0;
                                chan_next  = '0;
                                rate_next  = '0;
                                align_next = '0;
                                bits_next  = '0;
                                seen_next  = 1'b0;
                                phase_next = PH_FMT;
                            end
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            if (!seen_reg)
                            begin
                                term_v = 1'b1; term_code = ERR_NO_FMT_YET; fin_next = 1'b1;
                            end
                            else if (align_reg == '0 || div_rem != '0)
                            begin
                                term_v = 1'b1; term_code = ERR_DATA_FRAC; fin_next = 1'b1;
                            end
                            else if (len_next == '0)
                            begin
                                term_v    = 1'b1;
                                term_code = cancel_reg ? ERR_CANCEL : ERR_DATA_EMPTY;
                                fin_next  = 1'b1;
                            end
                            else
                            begin
                                left_next   = {1'b0, len_next};
                                chidx_next  = '0;
                                sum_next    = '0;
                                frames_next = '0;
                                phase_next  = PH_DATA;
                            end
                        end
                        else
                        begin
                            if (len_next == 32'hFFFF_FFFF)
                            begin
                                term_v = 1'b1; term_code = ERR_SKIP_LEN; fin_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = {1'b0, len_next} + 33'(len_next[0]);
                                phase_next = (left_next != '0) ? PH_SKIP : PH_TAG;
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    if (fi < 4'd2)
                        code_next[{fi[0], 3'b000} +: 8] = byte_reg;
                    else if (fi < 4'd4)
                        chan_next[{fi[0], 3'b000} +: 8] = byte_reg;
                    else if (fi < 4'd8)
                        rate_next[{fi[1:0], 3'b000} +: 8] = byte_reg;
                    else if (fi >= 4'd12 && fi < 4'd14)
                        align_next[{fi[0], 3'b000} +: 8] = byte_reg;
                    else if (fi >= 4'd14)
                        bits_next[{fi[0], 3'b000} +: 8] = byte_reg;
                    fbi_next = fbi_reg + 1'b1;
                    if (fbi_next >= 5'd16)
                    begin
                        if (code_next != 16'd1)
                            chk = ERR_NOT_PCM;
                        else if (chan_next == '0 || chan_next > 16'(MAX_CHANNELS))
                            chk = ERR_CHANNELS;
                        else if (rate_next == '0)
                            chk = ERR_RATE;
                        else if (bits_next != 16'd16)
                            chk = ERR_BITS;
                        else if (align_next != {chan_next[14:0], 1'b0})
                            chk = ERR_ALIGN;
                        if (chk != ST_OK)
                        begin
                            term_v = 1'b1; term_code = chk; fin_next = 1'b1;
                        end
                        else
                        begin
                            seen_next  = 1'b1;
                            fbi_next   = '0;
                            left_next  = {1'b0, len_reg - 32'd16} + 33'(len_reg[0]);
                            phase_next = (left_next != '0) ? PH_SKIP : PH_TAG;
                        end
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - 1'b1;
                    if (left_next == '0)
                    begin
                        phase_next = PH_TAG;
                        fbi_next   = '0;
                    end
                end
                PH_DATA:
                begin
                    if (first_cancel)
                    begin
                        term_v = 1'b1; term_code = ERR_CANCEL; fin_next = 1'b1;
                    end
                    else
                    begin
                        if (fbi_reg == 5'd0)
                        begin
                            low_next = byte_reg;
                            fbi_next = 5'd1;
                        end
                        else
                        begin
                            fbi_next   = '0;
                            chidx_next = chidx_inc;
                            sum_next   = sum_add;
                            if (frame_end)
                            begin
                                smp_v       = 1'b1;
                                smp         = sum_add[SUM_W-1] ? 16'(-div_quo[15:0])
                                                               : div_quo[15:0];
                                frames_next = frames_reg + 1'b1;
                                chidx_next  = '0;
                                sum_next    = '0;
                            end
                        end
                        left_next = left_reg - 1'b1;
                        if (left_next == '0)
                        begin
                            term_v   = 1'b1;
                            fin_next = 1'b1;
                            if (cancel_reg)
                                term_code = ERR_CANCEL;
                            else
                                term_kind = KIND_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (eof_reg)
        begin
            if (!fin_next)
            begin
                term_v = 1'b1;
                unique case (phase_next)
                    PH_HEAD: term_code = ERR_HDR_SHORT;
                    PH_SIZE: term_code = ERR_LEN_SHORT;
                    PH_FMT:  term_code = ERR_FMT_SHORT;
                    PH_DATA: term_code = ERR_DATA_SHORT;
                    default: term_code = seen_next ? ERR_DATA_MISS : ERR_FMT_MISS;
                endcase
            end
            phase_next  = PH_HEAD;
            fbi_next    = '0;
            tag_next    = '0;
            len_next    = '0;
            left_next   = '0;
            code_next   = '0;
            chan_next   = '0;
            rate_next   = '0;
            align_next  = '0;
            bits_next   = '0;
            seen_next   = 1'b0;
            sum_next    = '0;
            chidx_next  = '0;
            low_next    = '0;
            frames_next = '0;
            fin_next    = 1'b0;
            riff_next   = 1'b0;
        end
    end

    always_comb
    begin
        res0 = '0;
        res1 = '0;
        res1.kind = term_kind;
        res1.last = 1'b1;
        if (term_kind == KIND_DONE)
        begin
            res1.rate   = rate_reg;
            res1.chans  = chan_reg[6:0];
            res1.frames = frames_reg + 32'(smp_v);
        end
        else
            res1.code = term_code;
        if (smp_v)
        begin
            res0.kind   = KIND_SAMPLE;
            res0.sample = smp;
        end
        else
            res0 = res1;
    end

    assign push0_v = cmd.exec && (smp_v || term_v);
    assign push1_v = cmd.exec && smp_v && term_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            fbi_reg    <= '0;
            tag_reg    <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            code_reg   <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            align_reg  <= '0;
            bits_reg   <= '0;
            seen_reg   <= 1'b0;
            sum_reg    <= '0;
            chidx_reg  <= '0;
            low_reg    <= '0;
            frames_reg <= '0;
            fin_reg    <= 1'b0;
            riff_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            phase_reg  <= phase_next;
            fbi_reg    <= fbi_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            code_reg   <= code_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            align_reg  <= align_next;
            bits_reg   <= bits_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            chidx_reg  <= chidx_next;
            low_reg    <= low_next;
            frames_reg <= frames_next;
            fin_reg    <= fin_next;
            riff_reg   <= riff_next;
        end
    end

endmodule

FILE: rtl/core/wav_pcm16_parse_downmix.sv
// Byte-serial WAV parser: each input beat goes through latch, decode and
// update steps; a new beat is stalled until the last one is done. Beats
// that close a frame or a data chunk length also wait for the shared
// 32-step restoring divider. A result enters the output queue in the
// update step, which waits while the queue still holds earlier results.
// rst_n clears all control and parse state asynchronously; no clearing pass.
module wav_pcm16_parse_downmix
    import wpd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         stream_byte,
    input  logic               end_of_file,
    input  logic               cancel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [15:0] mono_sample,
    output logic [4:0]         status_code,
    output logic [31:0]        rate_hz,
    output logic [6:0]         channels_in,
    output logic [31:0]        frames_total,
    output logic               last_result
);

    cmd_t             cmd;
    sts_t             sts;
    logic             need_div, div_busy, q_empty;
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic [7:0]       div_divisor, div_rem;
    logic             push0_v, push1_v;
    res_t             res0, res1;

    assign sts.need_div = need_div;
    assign sts.div_busy = div_busy;
    assign sts.q_empty  = q_empty;

    wpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpd_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stream_byte  (stream_byte),
        .end_of_file  (end_of_file),
        .cancel       (cancel),
        .need_div     (need_div),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quo      (div_quo),
        .div_rem      (div_rem),
        .push0_v      (push0_v),
        .push1_v      (push1_v),
        .res0         (res0),
        .res1         (res1)
    );

    wpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    wpd_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push0_v      (push0_v),
        .push1_v      (push1_v),
        .res0         (res0),
        .res1         (res1),
        .q_empty      (q_empty),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .mono_sample  (mono_sample),
        .status_code  (status_code),
        .rate_hz      (rate_hz),
        .channels_in  (channels_in),
        .frames_total (frames_total),
        .last_result  (last_result)
    );

endmodule
